### hw/rtl/first_unique_symbol_stream_top_assert.svh
// Assertion macros for the first unique symbol stream block.
`ifndef FIRST_UNIQUE_SYMBOL_STREAM_TOP_ASSERT_SVH
`define FIRST_UNIQUE_SYMBOL_STREAM_TOP_ASSERT_SVH

// Same-cycle check: when ante holds, cons must hold too.
`define FUS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: when ante holds, cons must hold in the next cycle.
`define FUS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/fus_pkg.sv
// Shared constants and types for the first unique symbol stream block.
package fus_pkg;

    localparam int ALPHABET = 26;
    localparam int SYM_W    = 5;
    localparam int IDX_W    = $clog2(ALPHABET);
    localparam int FILL_W   = $clog2(ALPHABET + 1);
    localparam int CNT_W    = 2;

    // saturating occurrence count codes
    localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONCE = 2'd1;
    localparam logic [CNT_W-1:0] CNT_MANY = 2'd2;

    // command bundle for the count memory
    typedef struct packed {
        logic             clr;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [CNT_W-1:0] wr_data;
    } cnt_cmd_t;

endpackage

### hw/rtl/first_unique_symbol_stream_top.sv
// First unique symbol stream: top level with arrival queue and control sequencer.
//
// Each input transaction carries one symbol (0 for a through 25 for z) and a
// start_req flag that clears all counts and the queue before the symbol is
// handled. Each input transaction yields exactly one output transaction:
// found = 1 with first_unique = the earliest symbol of the current stream
// seen exactly once, or found = 0 with first_unique = 0. Symbols of 26 and up
// change nothing and just report the current answer. An item is first
// accepted and its count read from the count memory; then the count is
// written back, new symbols are appended to the queue and the result is
// formed. When the symbol repeats the current queue head, the head is dropped
// in that update step at no extra cost. Every further queue entry that has to
// be checked then goes through a queue memory read, a count memory read and a
// compare. Each symbol is dropped at most once per stream. If the output
// register is still held by res_stall when a result is ready, the result waits
// in a holding register with the input stalled. It moves to the output
// register at the same edge at which the old result is taken, so the wait
// lasts exactly as long as res_stall holds the old result. A new input
// transaction is accepted while the previous result still waits in the output
// register. Both memories have registered reads; the count memory is cleared
// by valid bits, so start_req needs no clearing state of its own.
module first_unique_symbol_stream_top
    import fus_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sym_valid,
    output logic             sym_stall,
    input  logic [SYM_W-1:0] letter,
    input  logic             start_req,
    output logic             res_valid,
    input  logic             res_stall,
    output logic             found,
    output logic [SYM_W-1:0] first_unique
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_QRD,
        S_QCHK,
        S_CCHK,
        S_EMIT
    } state_t;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        ring_next = (idx == IDX_W'(ALPHABET - 1)) ? '0 : idx + 1'b1;
    endfunction

    state_t            state_reg, state_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic              in_range_reg, in_range_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SYM_W-1:0]  head_sym_reg, head_sym_next;
    logic              res_found_reg, res_found_next;
    logic [SYM_W-1:0]  res_sym_reg, res_sym_next;
    logic              out_valid_reg, out_valid_next;
    logic              found_reg, found_next;
    logic [SYM_W-1:0]  uniq_reg, uniq_next;

    // arrival-ordered queue of first occurrences
    logic [SYM_W-1:0]  queue_mem [ALPHABET];
    logic [SYM_W-1:0]  qdata_reg;
    logic              q_wr_en;
    logic              q_rd_en;

    cnt_cmd_t          cnt_cmd;
    logic [CNT_W-1:0]  cnt_rd_data;

    logic              acc;
    logic              out_free;
    logic              fin;
    logic              fin_found;
    logic [SYM_W-1:0]  fin_sym;

    fus_cnt_mem u_cnt_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cnt_cmd),
        .rd_data (cnt_rd_data)
    );

    assign sym_stall = (state_reg != S_IDLE);
    assign acc       = sym_valid && !sym_stall;
    assign out_free  = !out_valid_reg || !res_stall;

    always_ff @(posedge clk)
    begin
        if (q_wr_en)
        begin
            queue_mem[tail_reg] <= sym_reg;
        end
        if (q_rd_en)
        begin
            qdata_reg <= queue_mem[head_reg];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sym_next       = sym_reg;
        in_range_next  = in_range_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        head_sym_next  = head_sym_reg;
        res_found_next = res_found_reg;
        res_sym_next   = res_sym_reg;
        found_next     = found_reg;
        uniq_next      = uniq_reg;
        out_valid_next = (out_valid_reg && !res_stall) ? 1'b0 : out_valid_reg;
        cnt_cmd        = '0;
        q_wr_en        = 1'b0;
        q_rd_en        = 1'b0;
        fin            = 1'b0;
        fin_found      = 1'b0;
        fin_sym        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    sym_next       = letter;
                    in_range_next  = (int'(letter) < ALPHABET);
                    cnt_cmd.clr    = start_req;
                    cnt_cmd.rd_en  = (int'(letter) < ALPHABET);
                    cnt_cmd.rd_addr = IDX_W'(letter);
                    if (start_req)
                    begin
                        head_next = '0;
                        tail_next = '0;
                        fill_next = '0;
                    end
                    state_next = S_UPD;
                end
            end

            S_UPD:
            begin
                if (in_range_reg)
                begin
                    cnt_cmd.wr_en   = 1'b1;
                    cnt_cmd.wr_addr = IDX_W'(sym_reg);
                    cnt_cmd.wr_data = (cnt_rd_data == CNT_NONE) ? CNT_ONCE : CNT_MANY;
                end
                if (in_range_reg && cnt_rd_data == CNT_NONE)
                begin
                    // first occurrence: append, becomes head if queue was empty
                    if (fill_reg < FILL_W'(ALPHABET))
                    begin
                        q_wr_en   = 1'b1;
                        tail_next = ring_next(tail_reg);
                        fill_next = fill_reg + 1'b1;
                        if (fill_reg == '0)
                        begin
                            head_sym_next = sym_reg;
                        end
                    end
                    fin       = 1'b1;
                    fin_found = 1'b1;
                    fin_sym   = (fill_reg == '0) ? sym_reg : head_sym_reg;
                end
                else if (in_range_reg && fill_reg != '0 && sym_reg == head_sym_reg)
                begin
                    // head repeated: drop it and scan for the next unique one
                    head_next = ring_next(head_reg);
                    fill_next = fill_reg - 1'b1;
                    if (fill_reg == FILL_W'(1))
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        state_next = S_QRD;
                    end
                end
                else
                begin
                    fin       = 1'b1;
                    fin_found = (fill_reg != '0);
                    fin_sym   = head_sym_reg;
                end
            end

            S_QRD:
            begin
                q_rd_en    = 1'b1;
                state_next = S_QCHK;
            end

            S_QCHK:
            begin
                cnt_cmd.rd_en   = 1'b1;
                cnt_cmd.rd_addr = IDX_W'(qdata_reg);
                state_next      = S_CCHK;
            end

            S_CCHK:
            begin
                if (cnt_rd_data > CNT_ONCE)
                begin
                    head_next = ring_next(head_reg);
                    fill_next = fill_reg - 1'b1;
                    if (fill_reg == FILL_W'(1))
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        state_next = S_QRD;
                    end
                end
                else
                begin
                    head_sym_next = qdata_reg;
                    fin           = 1'b1;
                    fin_found     = 1'b1;
                    fin_sym       = qdata_reg;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = res_found_reg;
                    uniq_next      = res_sym_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // result goes straight to the output register when it is free
        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                found_next     = fin_found;
                uniq_next      = fin_found ? fin_sym : '0;
                state_next     = S_IDLE;
            end
            else
            begin
                res_found_next = fin_found;
                res_sym_next   = fin_found ? fin_sym : '0;
                state_next     = S_EMIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sym_reg       <= '0;
            in_range_reg  <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            head_sym_reg  <= '0;
            res_found_reg <= 1'b0;
            res_sym_reg   <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            uniq_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sym_reg       <= sym_next;
            in_range_reg  <= in_range_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            head_sym_reg  <= head_sym_next;
            res_found_reg <= res_found_next;
            res_sym_reg   <= res_sym_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            uniq_reg      <= uniq_next;
        end
    end

    assign res_valid    = out_valid_reg;
    assign found        = found_reg;
    assign first_unique = uniq_reg;

`include "first_unique_symbol_stream_top_assert.svh"

    // queue never holds more than one entry per symbol
    `FUS_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(ALPHABET), "queue fill overflow")
    // an empty queue has its read and write pointers together
    `FUS_ASSERT_NOW(a_empty_ptrs, fill_reg == '0, head_reg == tail_reg, "empty queue pointers differ")
    // a "none" answer always carries a zero symbol
    `FUS_ASSERT_NOW(a_none_zero, res_valid && !found, first_unique == '0, "none result not zero")
    // an accepted transaction always proceeds to the count update
    `FUS_ASSERT_NEXT(a_acc_upd, acc, state_reg == S_UPD, "accept did not start update")

endmodule

### hw/rtl/fus_cnt_mem.sv
// Per-symbol count memory with registered reads and valid bits for clearing.
module fus_cnt_mem
    import fus_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cnt_cmd_t         cmd,
    output logic [CNT_W-1:0] rd_data
);

    logic [CNT_W-1:0]    mem [ALPHABET];
    logic [ALPHABET-1:0] vld_reg;
    logic [CNT_W-1:0]    data_reg;
    logic                hit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            data_reg <= mem[cmd.rd_addr];
        end
    end

    // a clear in the read cycle makes the read return zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                vld_reg <= '0;
            end
            else if (cmd.wr_en)
            begin
                vld_reg[cmd.wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                hit_reg <= vld_reg[cmd.rd_addr] & ~cmd.clr;
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : CNT_NONE;

endmodule
